/* src/scrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package scrf_pkg;

    localparam int RegCountDefault = 256;

    // access kinds carried on the input tuser bit
    localparam logic ActRead  = 1'b0;
    localparam logic ActWrite = 1'b1;

    // controller variants
    localparam logic [1:0] VarRetailP01 = 2'd0;
    localparam logic [1:0] VarRetailP05 = 2'd1;
    localparam logic [1:0] VarDebugDxb  = 2'd2;
    localparam logic [1:0] VarReset     = VarRetailP05;

    // special register addresses
    localparam logic [7:0] AddrVersion    = 8'h01;
    localparam logic [7:0] AddrLedMode    = 8'h07;
    localparam logic [7:0] AddrLedPattern = 8'h08;
    localparam logic [7:0] AddrScratch    = 8'h0E;
    localparam logic [7:0] AddrScratchMir = 8'h0F;
    localparam logic [7:0] AddrChalFirst  = 8'h1C;
    localparam logic [7:0] AddrChalLast   = 8'h1F;
    localparam logic [7:0] AddrInit04     = 8'h04;

    localparam logic [7:0] LedFixedPattern = 8'h0F;
    localparam logic [7:0] LedModeFixed    = 8'h00;
    localparam logic [7:0] LedModeStored   = 8'h01;
    localparam logic [7:0] VersionRestart  = 8'h00;
    localparam logic [1:0] VersionPosLast  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } scrf_state_t;

    // what the lookup cycle does with the ram word
    typedef struct packed {
        logic       to_led;     // byte goes to the led pattern, not read data
        logic       from_mem;   // byte comes from the ram
        logic       mem_valid;  // ram entry was written since reset
        logic [7:0] value;      // constant byte, or reset value of the entry
    } scrf_stage_t;

    function automatic logic [1:0] variant_row(input logic [1:0] v);
        return (v >= VarDebugDxb) ? VarDebugDxb : v;
    endfunction

    function automatic logic [1:0] version_advance(input logic [1:0] p);
        logic [1:0] n;
        case (p)
            2'd0:    n = 2'd1;
            2'd1:    n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] version_char(input logic [1:0] row, input logic [1:0] p);
        logic [7:0] c;
        case ({row, p})
            4'b0000: c = "P";
            4'b0001: c = "0";
            4'b0010: c = "1";
            4'b0100: c = "P";
            4'b0101: c = "0";
            4'b0110: c = "5";
            4'b1000: c = "D";
            4'b1001: c = "X";
            4'b1010: c = "B";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // register contents after reset; version register is never read back
    function automatic logic [7:0] reset_byte(input logic [7:0] a);
        logic [7:0] b;
        case (a)
            AddrInit04:     b = 8'h02;
            AddrLedPattern: b = LedFixedPattern;
            default:        b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* src/scrf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module scrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/system_controller_register_file_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | tdata (low bit up)                 | tuser
// s_      | in        | reg_addr[7:0], write_value[15:8]   | action (0 read, 1 write)
// m_      | out       | read_data[7:0], led_pattern[15:8]  | led_update
// cfg_    | in        | controller_variant[1:0]            | -
//
// the accept beat (idle state) issues the ram read, and the lookup state forms the
// result in the output register once that register is free; the registered ram
// read sets this, so no new access is taken until the lookup state is left
// reset clears the valid bits, the fsm and the output valid flag; entries not yet
// written read as their initial value, so there is no clearing pass
// a result waiting on m_tready does not block the next accept; a second result
// holds in the lookup stage until the output register frees

module system_controller_register_file_top
    import scrf_pkg::*;
#(
    parameter int REGISTER_COUNT = RegCountDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input accesses
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // reg_addr[7:0], write_value[15:8]
    input  wire logic        s_tuser,   // action
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // read_data[7:0], led_pattern[15:8]
    output logic             m_tuser,   // led_update
    // variant select
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);

    localparam int AddrW = $clog2(REGISTER_COUNT);
    localparam logic [8:0] CountLim = 9'(REGISTER_COUNT);

    scrf_state_t      st_reg, st_next;
    scrf_stage_t      stage_reg, stage_next;
    logic [1:0]       variant_reg;
    logic [1:0]       pos_reg, pos_next;
    logic [REGISTER_COUNT-1:0] valid_reg, valid_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [15:0]      m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    logic             in_beat;
    logic [7:0]       addr;
    logic [7:0]       wval;
    logic [7:0]       raddr;
    logic [1:0]       row;
    logic             mem_we;
    logic             mem_re;
    logic [7:0]       mem_rdata;
    logic             advance;
    logic [7:0]       res_byte;

    assign addr      = s_tdata[7:0];
    assign wval      = s_tdata[15:8];
    assign s_tready  = (st_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign row       = variant_row(variant_reg);

    // scratch mirror and stored led pattern both read another entry
    always_comb begin
        raddr = addr;
        if (s_tuser == ActRead && addr == AddrScratchMir) begin
            raddr = AddrScratch;
        end else if (s_tuser == ActWrite) begin
            raddr = AddrLedPattern;
        end
    end

    // accept beat: decode, update position, issue ram access
    always_comb begin
        stage_next = stage_reg;
        pos_next   = pos_reg;
        valid_next = valid_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        if (in_beat) begin
            stage_next.to_led    = 1'b0;
            stage_next.from_mem  = 1'b0;
            stage_next.mem_valid = valid_reg[raddr[AddrW-1:0]];
            stage_next.value     = 8'h00;
            case (s_tuser)
                ActRead: begin
                    if (addr == AddrVersion) begin
                        pos_next         = version_advance(pos_reg);
                        stage_next.value = version_char(row, pos_next);
                    end else if (addr inside {[AddrChalFirst:AddrChalLast]}
                                 && row == VarDebugDxb) begin
                        stage_next.value = 8'h00;
                    end else if ({1'b0, raddr} < CountLim) begin
                        stage_next.from_mem = 1'b1;
                        stage_next.value    = reset_byte(raddr);
                        mem_re              = 1'b1;
                    end
                end
                default: begin
                    if (addr == AddrVersion) begin
                        if (wval == VersionRestart) begin
                            pos_next = VersionPosLast;
                        end
                    end else if (addr == AddrLedMode) begin
                        if (wval == LedModeFixed) begin
                            stage_next.to_led = 1'b1;
                            stage_next.value  = LedFixedPattern;
                        end else if (wval == LedModeStored) begin
                            stage_next.to_led   = 1'b1;
                            stage_next.from_mem = 1'b1;
                            stage_next.value    = reset_byte(raddr);
                            mem_re              = 1'b1;
                        end
                    end else if ({1'b0, addr} < CountLim) begin
                        mem_we                       = 1'b1;
                        valid_next[addr[AddrW-1:0]] = 1'b1;
                    end
                end
            endcase
        end
    end

    scrf_ram #(
        .WIDTH (8),
        .DEPTH (REGISTER_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (addr[AddrW-1:0]),
        .wr_data (wval),
        .rd_en   (mem_re),
        .rd_addr (raddr[AddrW-1:0]),
        .rd_data (mem_rdata)
    );

    // lookup cycle: pick the byte and steer it to read data or led pattern
    assign res_byte = (stage_reg.from_mem && stage_reg.mem_valid) ? mem_rdata : stage_reg.value;
    assign advance  = (st_reg == ST_LOOKUP) && (!m_tvalid_reg || m_tready);

    always_comb begin
        st_next       = st_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    st_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (advance) begin
                    st_next       = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = stage_reg.to_led;
                    m_tdata_next  = stage_reg.to_led ? {res_byte, 8'h00} : {8'h00, res_byte};
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            variant_reg  <= VarReset;
            pos_reg      <= VersionPosLast;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            pos_reg      <= pos_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                variant_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg   <= stage_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an accepted beat always moves to the lookup cycle
    a_accept_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> st_reg == ST_LOOKUP)
        else $error("accepted beat did not enter lookup");

    // a new result only comes out of a lookup cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(st_reg == ST_LOOKUP))
        else $error("result without lookup");

    // a led update never carries read data
    a_led_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata[7:0] == 8'h00)
        else $error("led update with nonzero read data");

    // the version position never reaches the unused code
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 2'd3)
        else $error("version position out of range");

endmodule

`default_nettype wire

/* test/tb_system_controller_register_file_top.sv */
`timescale 1ns / 1ps

module tb_system_controller_register_file_top;
    import scrf_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        logic       led_update;
        logic [7:0] led_pattern;
    } access_result_t;

    // unused variant code, behaves as the debug kit
    localparam logic [1:0] VarSpare = 2'd3;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // reg_addr[7:0], write_value[15:8]
    logic        s_tuser   = ActRead;   // action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // read_data[7:0], led_pattern[15:8]
    logic        m_tuser;           // led_update
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;

    system_controller_register_file_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow of the block state
    logic [7:0] shadow_regs [256];
    logic [1:0] shadow_pos;
    logic [1:0] shadow_variant;

    access_result_t pending_results [$];
    int mismatch_count   = 0;
    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver stalls at the rate of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [7:0] version_byte(input logic [1:0] variant,
                                                input logic [1:0] pos);
        logic [23:0] text;
        case (variant)
            VarRetailP01: text = "P01";
            VarRetailP05: text = "P05";
            default:      text = "DXB";
        endcase
        case (pos)
            2'd0:    return text[23:16];
            2'd1:    return text[15:8];
            default: return text[7:0];
        endcase
    endfunction

    task automatic reset_shadow();
        foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
        shadow_variant = VarReset;
        shadow_pos     = VersionPosLast;
        shadow_regs[AddrVersion]    = version_byte(VarReset, VersionPosLast);
        shadow_regs[AddrInit04]     = 8'h02;
        shadow_regs[AddrLedPattern] = LedFixedPattern;
    endtask

    // applies one access to the shadow state and returns the result it gives
    function automatic access_result_t predict_access(input logic act,
                                                      input logic [7:0] addr,
                                                      input logic [7:0] value);
        access_result_t r;
        logic debug_kit;
        r = '0;
        debug_kit = (shadow_variant >= VarDebugDxb);
        if (act == ActRead) begin
            if (addr == AddrVersion) begin
                shadow_pos  = (shadow_pos == 2'd0) ? 2'd1 : (shadow_pos == 2'd1) ? 2'd2 : 2'd0;
                r.read_data = version_byte(shadow_variant, shadow_pos);
            end else if (addr == AddrScratchMir) begin
                r.read_data = shadow_regs[AddrScratch];
            end else if (addr >= AddrChalFirst && addr <= AddrChalLast && debug_kit) begin
                r.read_data = 8'h00;
            end else begin
                r.read_data = shadow_regs[addr];
            end
        end else if (addr == AddrVersion) begin
            if (value == VersionRestart) shadow_pos = VersionPosLast;
        end else if (addr == AddrLedMode) begin
            if (value == LedModeFixed) begin
                r.led_update  = 1'b1;
                r.led_pattern = LedFixedPattern;
            end else if (value == LedModeStored) begin
                r.led_update  = 1'b1;
                r.led_pattern = shadow_regs[AddrLedPattern];
            end
        end else begin
            shadow_regs[addr] = value;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // watches all three channels at each edge: config, accepted accesses, results
    always @(posedge aclk) begin : monitor
        access_result_t got;
        access_result_t want;
        if (!aresetn) begin
            reset_shadow();
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                shadow_variant = cfg_data;
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_access(s_tuser, s_tdata[7:0], s_tdata[15:8]));
            if (m_tvalid && m_tready) begin
                got.read_data   = m_tdata[7:0];
                got.led_pattern = m_tdata[15:8];
                got.led_update  = m_tuser;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", int'(m_tdata), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", int'(got.read_data),
                                        int'(want.read_data));
                    if (got.led_update !== want.led_update)
                        report_mismatch("led_update", int'(got.led_update),
                                        int'(want.led_update));
                    if (got.led_pattern !== want.led_pattern)
                        report_mismatch("led_pattern", int'(got.led_pattern),
                                        int'(want.led_pattern));
                end
            end
        end
    end

    // one access; valid stays high into the next access when no gap is drawn
    task automatic send_access(input logic act, input logic [7:0] addr, input logic [7:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {value, addr};
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender holds off until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_variant(input logic [1:0] variant);
        cfg_valid <= 1'b1;
        cfg_data  <= variant;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_values();
        send_access(ActRead, 8'h00, 8'hFF);
        send_access(ActRead, AddrInit04, 8'h00);
        send_access(ActRead, AddrLedPattern, 8'h00);
        send_access(ActRead, 8'hFF, 8'h00);
        send_access(ActWrite, 8'hFF, 8'hFF);
        send_access(ActRead, 8'hFF, 8'h00);
        send_access(ActWrite, 8'h00, 8'h00);
    endtask

    task automatic test_version_cycle();
        repeat (4) send_access(ActRead, AddrVersion, 8'h00);
        send_access(ActWrite, AddrVersion, VersionRestart);
        send_access(ActRead, AddrVersion, 8'h00);
        // nonzero write leaves the position alone and is not stored
        send_access(ActWrite, AddrVersion, 8'h55);
        send_access(ActRead, AddrVersion, 8'h00);
    endtask

    task automatic test_scratch_mirror();
        send_access(ActWrite, AddrScratch, 8'hA5);
        send_access(ActWrite, AddrScratchMir, 8'h3C);
        send_access(ActRead, AddrScratchMir, 8'h00);
        send_access(ActRead, AddrScratch, 8'h00);
    endtask

    task automatic test_led_mode();
        send_access(ActWrite, AddrLedMode, LedModeFixed);
        send_access(ActWrite, AddrLedMode, LedModeStored);
        send_access(ActWrite, AddrLedPattern, 8'h5A);
        send_access(ActWrite, AddrLedMode, LedModeStored);
        send_access(ActWrite, AddrLedMode, 8'hFF);
        send_access(ActRead, AddrLedMode, 8'h00);
    endtask

    // challenge bytes hide on the debug kit; variant change keeps the position
    task automatic test_challenge_regs();
        for (int a = int'(AddrChalFirst); a <= int'(AddrChalLast); a++)
            send_access(ActWrite, a[7:0], 8'hC0 | a[7:0]);
        send_access(ActRead, AddrChalFirst, 8'h00);
        send_access(ActRead, AddrVersion, 8'h00);
        drain_results();
        write_variant(VarDebugDxb);
        send_access(ActRead, AddrVersion, 8'h00);
        for (int a = int'(AddrChalFirst); a <= int'(AddrChalLast); a++)
            send_access(ActRead, a[7:0], 8'h00);
        drain_results();
        // unused code behaves as the debug kit
        write_variant(VarSpare);
        send_access(ActRead, AddrChalLast, 8'h00);
        send_access(ActRead, AddrVersion, 8'h00);
        drain_results();
        write_variant(VarRetailP01);
        send_access(ActRead, AddrVersion, 8'h00);
        send_access(ActRead, AddrChalLast, 8'h00);
        drain_results();
    endtask

    function automatic logic [7:0] pick_addr();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            case ($urandom_range(9))
                0:       return AddrVersion;
                1:       return AddrLedMode;
                2:       return AddrLedPattern;
                3:       return AddrScratch;
                4:       return AddrScratchMir;
                5:       return AddrInit04;
                6:       return AddrChalFirst;
                7:       return AddrChalLast;
                8:       return AddrChalFirst + 8'd1;
                default: return AddrChalFirst + 8'd2;
            endcase
        end
        if (r < 55) return 8'($urandom_range(8'h1F));
        return 8'($urandom_range(255));
    endfunction

    task automatic test_random_phase(input int count, input logic [1:0] variant,
                                     input int idle_pct, input int stall_pct);
        logic       act;
        logic [7:0] addr;
        logic [7:0] value;
        drain_results();
        write_variant(variant);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            act  = 1'($urandom_range(1));
            addr = pick_addr();
            // led mode register reacts to 0 and 1, version register to 0
            if ((addr == AddrVersion || addr == AddrLedMode) && $urandom_range(1))
                value = 8'($urandom_range(1));
            else
                value = 8'($urandom_range(255));
            send_access(act, addr, value);
        end
        drain_results();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_version_cycle();
        test_scratch_mirror();
        test_led_mode();
        test_challenge_regs();

        test_random_phase(340, VarRetailP05, 0, 0);
        test_random_phase(340, VarRetailP01, 55, 0);
        test_random_phase(340, VarDebugDxb, 0, 55);
        test_random_phase(340, VarSpare, 17, 17);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
